### rtl/tsc_pkg.sv
// shared constants and types for the taylor sine cosine unit
package tsc_pkg;

  localparam int AngleW  = 31;
  localparam int ValueW  = 31;
  localparam int TermsW  = 5;
  localparam int ThreshW = 29;
  localparam int MagW    = 31;
  localparam int X2W     = 32;
  localparam int SumW    = 36;

  localparam logic signed [AngleW-1:0] AngleMax    = 31'sd843314857;
  localparam logic [MagW-1:0]          OneQ28      = 31'd268435456;
  localparam logic [ThreshW-1:0]       ThreshReset = 29'd2684;
  localparam logic signed [SumW-1:0]   ValueMax    = 36'sd1073741823;
  localparam logic signed [SumW-1:0]   ValueMin    = -36'sd1073741824;

  // per-term state carried down the pipeline
  typedef struct packed {
    logic                   vld;
    logic                   done;
    logic                   neg;
    logic [4:0]             n;
    logic [TermsW-1:0]      terms;
    logic [MagW-1:0]        mag;
    logic [X2W-1:0]         x2;
    logic signed [SumW-1:0] sum;
  } term_t;

  // q0.32 reciprocal of (n+1)(n+2), rounded
  function automatic logic [31:0] recip_q32(input logic [4:0] n);
    logic [31:0] r;
    case (n)
      5'd0:    r = 32'd2147483648;
      5'd1:    r = 32'd715827883;
      5'd2:    r = 32'd357913941;
      5'd3:    r = 32'd214748365;
      5'd4:    r = 32'd143165577;
      5'd5:    r = 32'd102261126;
      5'd6:    r = 32'd76695845;
      5'd7:    r = 32'd59652324;
      5'd8:    r = 32'd47721859;
      5'd9:    r = 32'd39045157;
      5'd10:   r = 32'd32537631;
      5'd11:   r = 32'd27531842;
      5'd12:   r = 32'd23598721;
      5'd13:   r = 32'd20452225;
      5'd14:   r = 32'd17895697;
      5'd15:   r = 32'd15790321;
      5'd16:   r = 32'd14035841;
      5'd17:   r = 32'd12558384;
      5'd18:   r = 32'd11302546;
      5'd19:   r = 32'd10226113;
      5'd20:   r = 32'd9296466;
      5'd21:   r = 32'd8488078;
      5'd22:   r = 32'd7780738;
      5'd23:   r = 32'd7158279;
      5'd24:   r = 32'd6607642;
      5'd25:   r = 32'd6118187;
      5'd26:   r = 32'd5681174;
      5'd27:   r = 32'd5289369;
      5'd28:   r = 32'd4936744;
      5'd29:   r = 32'd4618244;
      5'd30:   r = 32'd4329604;
      default: r = 32'd4067204;
    endcase
    return r;
  endfunction

endpackage

### rtl/taylor_sine_cosine_unit.sv
// Taylor sine/cosine unit: top level, pipeline control and output saturation
//
// Input word: action_i (0 sine, 1 cosine) and angle_i (signed Q3.28 radians),
// taken when in_valid_i is high and in_stall_o low. Angles beyond +/- pi are
// clamped. Output word: value_o (signed Q3.28) and terms_used_o, offered with
// out_valid_o and taken when out_stall_i is low.
// The series is unrolled into MAX_TERMS term sections of two register stages
// each, every stage holding one multiplier. One word enters per cycle unless
// the held output word is stalled. A term section whose item has already met
// the stop test passes it through unchanged.
// stop_threshold is written with cfg_we_i / cfg_wdata_i (reset 2684).
// Reset empties the pipeline. A stall of the output freezes the whole
// pipeline when the output word is held, so nothing is lost or repeated.
module taylor_sine_cosine_unit import tsc_pkg::*; #(
  parameter int MAX_TERMS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ThreshW-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic signed [AngleW-1:0] angle_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [TermsW-1:0]        terms_used_o
);

  logic [ThreshW-1:0] thresh_q;
  logic               en;
  term_t              pipe [MAX_TERMS+1];
  logic               out_vld_q;
  logic signed [ValueW-1:0] val_q;
  logic [TermsW-1:0]  trm_q;
  logic signed [SumW-1:0] s;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thresh_q <= ThreshReset;
    else if (cfg_we_i) thresh_q <= cfg_wdata_i;
  end

  // whole pipeline advances unless a held output word is stalled
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  tsc_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .action_i, .angle_i, .term_o(pipe[0])
  );

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_term
    tsc_term u_term (
      .clk_i, .rst_ni, .en_i(en),
      .max_terms_i(TermsW'(MAX_TERMS)), .thresh_i(thresh_q),
      .term_i(pipe[g]), .term_o(pipe[g+1])
    );
  end

  // output saturation
  always_comb begin
    s = pipe[MAX_TERMS].sum;
    if (s > ValueMax) s = ValueMax;
    else if (s < ValueMin) s = ValueMin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= pipe[MAX_TERMS].vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= s[ValueW-1:0];
      trm_q <= pipe[MAX_TERMS].terms;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_o      = val_q;
  assign terms_used_o = trm_q;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_o)))
    else $error("output word changed under stall");
  a_terms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (terms_used_o != 0 && terms_used_o <= TermsW'(MAX_TERMS)))
    else $error("terms count out of range");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");
`endif

endmodule

### rtl/tsc_prep.sv
// angle saturation, x squared and series start values
module tsc_prep import tsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic                     action_i,
  input  logic signed [AngleW-1:0] angle_i,
  output term_t                    term_o
);

  logic signed [AngleW-1:0] x_q, x_d;
  logic                     cos_q, vld_q;
  logic [AngleW-2:0]        xm;
  logic [61:0]              sq;
  term_t                    t_d, t_q;

  // saturate
  always_comb begin
    if (angle_i > AngleMax) x_d = AngleMax;
    else if (angle_i < -AngleMax) x_d = -AngleMax;
    else x_d = angle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      t_q.vld <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
      x_q   <= x_d;
      cos_q <= action_i;
      t_q   <= t_d;
    end
  end

  // square and initial term
  always_comb begin
    xm = x_q[AngleW-1] ? (AngleW-1)'(-x_q) : x_q[AngleW-2:0];
    sq = 62'(xm) * 62'(xm) + (62'd1 << 27);
    t_d.vld   = vld_q;
    t_d.done  = 1'b0;
    t_d.terms = '0;
    t_d.x2    = sq[59:28];
    if (cos_q) begin
      t_d.sum = SumW'(OneQ28);
      t_d.mag = OneQ28;
      t_d.neg = 1'b0;
      t_d.n   = 5'd0;
    end else begin
      t_d.sum = SumW'(x_q);
      t_d.mag = MagW'(xm);
      t_d.neg = x_q[AngleW-1];
      t_d.n   = 5'd1;
    end
  end

  assign term_o = t_q;

endmodule

### rtl/tsc_term.sv
// one series term over two stages: times x squared, then times reciprocal
module tsc_term import tsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [TermsW-1:0]  max_terms_i,
  input  logic [ThreshW-1:0] thresh_i,
  input  term_t              term_i,
  output term_t              term_o
);

  term_t       a_q, b_q, b_d;
  logic [62:0] p1;
  logic [63:0] p2;
  logic [33:0] m1_q;
  logic [MagW-1:0] m2;
  logic [31:0] rc;

  // first multiply, the product can reach about 51 in q.28
  assign p1 = 63'(term_i.mag) * 63'(term_i.x2) + (63'd1 << 27);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q.vld <= 1'b0;
      b_q.vld <= 1'b0;
    end else if (en_i) begin
      a_q  <= term_i;
      m1_q <= p1[61:28];
      b_q  <= b_d;
    end
  end

  // second multiply, accumulate and stop test
  always_comb begin
    rc  = recip_q32(a_q.n);
    p2  = 64'(m1_q) * 64'(rc) + (64'd1 << 31);
    m2  = p2[62:32];
    b_d = a_q;
    if (!a_q.done) begin
      b_d.mag   = m2;
      b_d.neg   = !a_q.neg;
      b_d.sum   = a_q.neg ? a_q.sum + SumW'(m2) : a_q.sum - SumW'(m2);
      b_d.n     = a_q.n + 5'd2;
      b_d.terms = a_q.terms + 1'b1;
      b_d.done  = !((m2 > MagW'(thresh_i)) && (b_d.terms < max_terms_i));
    end
  end

  assign term_o = b_q;

endmodule
